/* rtl/bta_pkg.sv */
// block table allocator package: payload structs, command and status codes,
// controller/datapath command and status bundles
// no dependencies
package bta_pkg;

  localparam int REQ_W       = 16;
  localparam int OFF_W       = 16;
  localparam int GRANT_W     = 13;
  localparam int BYTES_W     = 14;
  localparam int PCT_W       = 7;
  localparam int PCT_SCALE   = 100;

  localparam logic [1:0] CMD_ALLOC = 2'd0;
  localparam logic [1:0] CMD_FREE  = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FAIL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic [1:0]       command;
    logic [REQ_W-1:0] request_bytes;
    logic [OFF_W-1:0] byte_offset;
  } bta_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [GRANT_W-1:0] granted_offset;
    logic [BYTES_W-1:0] allocated_bytes;
    logic [PCT_W-1:0]   usage_percent;
  } bta_out_t;

  typedef enum logic [1:0] {
    DIV_NEED  = 2'd0,
    DIV_INDEX = 2'd1,
    DIV_USAGE = 2'd2
  } div_sel_t;

  typedef struct packed {
    logic     clear_wr;
    logic     load;
    logic     div_start;
    div_sel_t div_sel;
    logic     need_load;
    logic     scan_init;
    logic     scan_step;
    logic     mark_init;
    logic     mark_wr;
    logic     set_fail;
    logic     set_range;
    logic     idx_load;
    logic     look_rd;
    logic     eval;
    logic     free_rd;
    logic     free_wr;
    logic     pct_load;
    logic     out_load;
  } bta_ctl_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       req_zero;
    logic       off_out;
    logic       div_done;
    logic       need_big;
    logic       scan_found;
    logic       scan_end;
    logic       mark_last;
    logic       entry_zero;
    logic       free_last;
    logic       clear_last;
    logic       out_busy;
  } bta_sts_t;

endpackage

/* rtl/bta_div.sv */
// constant divider by reciprocal multiplication, quotient registered in the cycle after start
// depends on nothing; used by bta_dp for block counts, indexes and usage
module bta_div #(
  parameter int NUM_W = 19,
  parameter int DEN_A = 32,
  parameter int DEN_B = 256
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             sel_b,
  input  logic [NUM_W-1:0] num,
  output logic             done,
  output logic [NUM_W-1:0] quo
);
  // shift of NUM_W plus ceil(log2(den)) keeps the rounded-up reciprocal exact
  // for every numerator below 2**NUM_W
  localparam int     SH_A  = NUM_W + $clog2(DEN_A);
  localparam int     SH_B  = NUM_W + $clog2(DEN_B);
  localparam longint RCP_A = ((longint'(1) << SH_A) + longint'(DEN_A - 1)) / longint'(DEN_A);
  localparam longint RCP_B = ((longint'(1) << SH_B) + longint'(DEN_B - 1)) / longint'(DEN_B);
  localparam int     RCP_W = NUM_W + 1;
  localparam int     PRD_W = NUM_W + RCP_W;

  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic             done_r;
  logic [RCP_W-1:0] rcp;
  logic [PRD_W-1:0] prod;

  assign rcp     = sel_b ? RCP_W'(RCP_B) : RCP_W'(RCP_A);
  assign prod    = PRD_W'(num) * PRD_W'(rcp);
  assign quo_nxt = sel_b ? NUM_W'(prod >> SH_B) : NUM_W'(prod >> SH_A);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else begin
      done_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= quo_nxt;
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

/* rtl/bta_dp.sv */
// allocator datapath: block table memory, counters, divider and result registers
// depends on bta_pkg and bta_div; driven by bta_ctrl through bta_ctl_t
module bta_dp #(
  parameter int BLOCK_BYTES   = 32,
  parameter int TABLE_ENTRIES = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  bta_pkg::bta_in_t  in_data,
  input  bta_pkg::bta_ctl_t ctl,
  output bta_pkg::bta_sts_t sts,
  input  logic              out_stall,
  output logic              out_valid,
  output bta_pkg::bta_out_t out_data
);
  import bta_pkg::*;

  localparam int EW      = $clog2(TABLE_ENTRIES + 1);
  localparam int IW      = $clog2(TABLE_ENTRIES);
  localparam int BBW     = $clog2(BLOCK_BYTES + 1);
  localparam int MAX_A   = (1 << REQ_W) - 1 + BLOCK_BYTES - 1;
  localparam int MAX_U   = TABLE_ENTRIES * PCT_SCALE;
  localparam int MAX_N   = (MAX_A > MAX_U) ? MAX_A : MAX_U;
  localparam int NUM_W   = $clog2(MAX_N + 1);
  localparam int GW      = (IW + BBW > GRANT_W) ? IW + BBW : GRANT_W;
  localparam int PW      = (EW + BBW > BYTES_W) ? EW + BBW : BYTES_W;
  localparam logic [31:0] POOL_BYTES = 32'(BLOCK_BYTES * TABLE_ENTRIES);

  logic [EW-1:0] mem [TABLE_ENTRIES];

  bta_in_t          req_r;
  logic [NUM_W-1:0] need_r;
  logic [IW-1:0]    idx_r, pidx_r;
  logic [EW-1:0]    run_r, cnt_r, used_r, rdata_r;
  logic             issue_r, pv_r;
  logic [1:0]       st_r;
  logic [GRANT_W-1:0] granted_r;
  logic [BYTES_W-1:0] bytes_r;
  logic [PCT_W-1:0]   pct_r;
  logic             out_valid_r;
  bta_out_t         out_r;

  logic [EW-1:0]    run_nxt;
  logic             found;
  logic             ren, wen;
  logic [EW-1:0]    wdata;
  logic [NUM_W-1:0] div_num, div_quo;
  logic             div_b;
  logic             div_done;
  logic [GW-1:0]    gprod;
  logic [PW-1:0]    bprod;
  logic [NUM_W-1:0] used_scaled;

  bta_div #(
    .NUM_W (NUM_W),
    .DEN_A (BLOCK_BYTES),
    .DEN_B (TABLE_ENTRIES)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (ctl.div_start),
    .sel_b (div_b),
    .num   (div_num),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign used_scaled = NUM_W'(used_r) * NUM_W'(PCT_SCALE);

  always_comb begin
    case (ctl.div_sel)
      DIV_NEED: begin
        div_num = NUM_W'(req_r.request_bytes) + NUM_W'(BLOCK_BYTES - 1);
        div_b   = 1'b0;
      end
      DIV_INDEX: begin
        div_num = NUM_W'(req_r.byte_offset);
        div_b   = 1'b0;
      end
      default: begin
        div_num = used_scaled;
        div_b   = 1'b1;
      end
    endcase
  end

  // run of free entries seen so far, counting downward
  assign run_nxt = (rdata_r == '0) ? run_r + EW'(1) : '0;
  assign found   = pv_r && (NUM_W'(run_nxt) == need_r);
  assign gprod   = GW'(pidx_r) * GW'(BLOCK_BYTES);
  assign bprod   = PW'(rdata_r) * PW'(BLOCK_BYTES);

  // every table access goes to idx_r
  assign ren = (ctl.scan_step && issue_r) || ctl.look_rd || ctl.free_rd;
  always_comb begin
    wen   = 1'b0;
    wdata = '0;
    if (ctl.clear_wr) begin
      wen = 1'b1;
    end else if (ctl.mark_wr) begin
      wen   = 1'b1;
      wdata = need_r[EW-1:0];
    end else if (ctl.free_wr && rdata_r != '0) begin
      wen = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wen) begin
      mem[idx_r] <= wdata;
    end
    if (ren) begin
      rdata_r <= mem[idx_r];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      issue_r     <= 1'b0;
      pv_r        <= 1'b0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctl.clear_wr || ctl.mark_wr || ctl.free_wr) begin
        idx_r <= idx_r + IW'(1);
      end
      if (ctl.scan_init) begin
        idx_r   <= IW'(TABLE_ENTRIES - 1);
        issue_r <= 1'b1;
        pv_r    <= 1'b0;
      end
      if (ctl.mark_init) begin
        idx_r   <= pidx_r;
        issue_r <= 1'b0;
        pv_r    <= 1'b0;
      end else if (ctl.scan_step) begin
        pv_r <= issue_r;
        if (issue_r) begin
          if (idx_r == '0) begin
            issue_r <= 1'b0;
          end else begin
            idx_r <= idx_r - IW'(1);
          end
        end
      end
      if (ctl.idx_load) begin
        idx_r <= div_quo[IW-1:0];
      end
      if (ctl.mark_wr) begin
        used_r <= used_r + EW'(1);
      end else if (ctl.free_wr && rdata_r != '0) begin
        used_r <= used_r - EW'(1);
      end
      if (ctl.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload and working registers
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      req_r     <= in_data;
      st_r      <= ST_OK;
      granted_r <= '0;
      bytes_r   <= '0;
    end
    if (ctl.need_load) begin
      need_r <= div_quo;
    end
    if (ctl.scan_init) begin
      run_r <= '0;
    end
    if (ctl.scan_step) begin
      pidx_r <= idx_r;
      if (pv_r) begin
        run_r <= run_nxt;
      end
    end
    if (ctl.mark_init) begin
      cnt_r     <= need_r[EW-1:0];
      granted_r <= gprod[GRANT_W-1:0];
    end
    if (ctl.mark_wr || ctl.free_wr) begin
      cnt_r <= cnt_r - EW'(1);
    end
    if (ctl.eval) begin
      if (req_r.command == CMD_QUERY) begin
        bytes_r <= bprod[BYTES_W-1:0];
      end else begin
        cnt_r <= rdata_r;
      end
    end
    if (ctl.set_fail) begin
      st_r <= ST_FAIL;
    end
    if (ctl.set_range) begin
      st_r <= ST_RANGE;
    end
    if (ctl.pct_load) begin
      pct_r <= div_quo[PCT_W-1:0];
    end
    if (ctl.out_load) begin
      out_r.status          <= st_r;
      out_r.granted_offset  <= granted_r;
      out_r.allocated_bytes <= bytes_r;
      out_r.usage_percent   <= pct_r;
    end
  end

  always_comb begin
    sts            = '0;
    sts.cmd        = req_r.command;
    sts.req_zero   = req_r.request_bytes == '0;
    sts.off_out    = 32'(req_r.byte_offset) >= POOL_BYTES;
    sts.div_done   = div_done;
    sts.need_big   = div_quo > NUM_W'(TABLE_ENTRIES);
    sts.scan_found = found;
    sts.scan_end   = pv_r && (pidx_r == '0) && !found;
    sts.mark_last  = cnt_r == EW'(1);
    sts.entry_zero = rdata_r == '0;
    sts.free_last  = (cnt_r == EW'(1)) || (idx_r == IW'(TABLE_ENTRIES - 1));
    sts.clear_last = idx_r == IW'(TABLE_ENTRIES - 1);
    sts.out_busy   = out_valid_r && out_stall;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

/* rtl/bta_ctrl.sv */
// allocator controller: one-hot sequencer for clear, allocate, free and query
// depends on bta_pkg; commands bta_dp through bta_ctl_t, reads bta_sts_t
module bta_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  bta_pkg::bta_sts_t sts,
  output bta_pkg::bta_ctl_t ctl
);
  import bta_pkg::*;

  typedef enum logic [13:0] {
    S_CLEAR    = 14'b00000000000001,
    S_IDLE     = 14'b00000000000010,
    S_DISPATCH = 14'b00000000000100,
    S_NEED     = 14'b00000000001000,
    S_SCAN     = 14'b00000000010000,
    S_MARK     = 14'b00000000100000,
    S_INDEX    = 14'b00000001000000,
    S_LOOK     = 14'b00000010000000,
    S_EVAL     = 14'b00000100000000,
    S_FREE_RD  = 14'b00001000000000,
    S_FREE_WR  = 14'b00010000000000,
    S_USE_GO   = 14'b00100000000000,
    S_USAGE    = 14'b01000000000000,
    S_FINISH   = 14'b10000000000000
  } state_t;

  state_t state_r, state_nxt;

  assign in_stall = state_r != S_IDLE;

  always_comb begin
    state_nxt   = state_r;
    ctl         = '0;
    ctl.div_sel = DIV_USAGE;
    case (state_r)
      S_CLEAR: begin
        ctl.clear_wr = 1'b1;
        if (sts.clear_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          ctl.load  = 1'b1;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (sts.cmd)
          CMD_ALLOC: begin
            if (sts.req_zero) begin
              ctl.set_fail = 1'b1;
              state_nxt    = S_USE_GO;
            end else begin
              ctl.div_start = 1'b1;
              ctl.div_sel   = DIV_NEED;
              state_nxt     = S_NEED;
            end
          end
          CMD_FREE, CMD_QUERY: begin
            if (sts.off_out) begin
              ctl.set_range = 1'b1;
              state_nxt     = S_USE_GO;
            end else begin
              ctl.div_start = 1'b1;
              ctl.div_sel   = DIV_INDEX;
              state_nxt     = S_INDEX;
            end
          end
          default: state_nxt = S_USE_GO;
        endcase
      end
      S_NEED: begin
        if (sts.div_done) begin
          ctl.need_load = 1'b1;
          if (sts.need_big) begin
            ctl.set_fail = 1'b1;
            state_nxt    = S_USE_GO;
          end else begin
            ctl.scan_init = 1'b1;
            state_nxt     = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        ctl.scan_step = 1'b1;
        if (sts.scan_found) begin
          ctl.mark_init = 1'b1;
          state_nxt     = S_MARK;
        end else if (sts.scan_end) begin
          ctl.set_fail = 1'b1;
          state_nxt    = S_USE_GO;
        end
      end
      S_MARK: begin
        ctl.mark_wr = 1'b1;
        if (sts.mark_last) begin
          state_nxt = S_USE_GO;
        end
      end
      S_INDEX: begin
        if (sts.div_done) begin
          ctl.idx_load = 1'b1;
          state_nxt    = S_LOOK;
        end
      end
      S_LOOK: begin
        ctl.look_rd = 1'b1;
        state_nxt   = S_EVAL;
      end
      S_EVAL: begin
        ctl.eval = 1'b1;
        // query, or free of a block that is already free
        if (sts.cmd == CMD_QUERY || sts.entry_zero) begin
          state_nxt = S_USE_GO;
        end else begin
          state_nxt = S_FREE_RD;
        end
      end
      S_FREE_RD: begin
        ctl.free_rd = 1'b1;
        state_nxt   = S_FREE_WR;
      end
      S_FREE_WR: begin
        ctl.free_wr = 1'b1;
        if (sts.free_last) begin
          state_nxt = S_USE_GO;
        end else begin
          state_nxt = S_FREE_RD;
        end
      end
      S_USE_GO: begin
        ctl.div_start = 1'b1;
        ctl.div_sel   = DIV_USAGE;
        state_nxt     = S_USAGE;
      end
      S_USAGE: begin
        if (sts.div_done) begin
          ctl.pct_load = 1'b1;
          state_nxt    = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!sts.out_busy) begin
          ctl.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* rtl/block_table_allocator_unit.sv */
// top level of the block table allocator: controller plus datapath
// depends on bta_pkg, bta_ctrl, bta_dp (and bta_div below it)
//
//   channel  handshake           payload
//   in       in_valid/in_stall   in_data  (command, request_bytes, byte_offset)
//   out      out_valid/out_stall out_data (status, granted_offset,
//                                          allocated_bytes, usage_percent)
//
// one transaction at a time; the table is one memory with a single access per cycle
// allocate scans the table from the top entry down for a run of need free entries
//   and fails when the scan finds no run; free clears count entries from its entry
//   (count clipped at the table end); query reads one entry; zero size, oversize,
//   range error and unused command skip the table; idle again before the next accept
// after reset a clearing pass zeroes every table entry before input is taken
// a result waiting under out_stall does not block work on the next transaction
module block_table_allocator_unit #(
  parameter int BLOCK_BYTES   = 32,
  parameter int TABLE_ENTRIES = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  bta_pkg::bta_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output bta_pkg::bta_out_t out_data
);
  import bta_pkg::*;

  bta_ctl_t ctl;
  bta_sts_t sts;

  bta_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .ctl      (ctl)
  );

  bta_dp #(
    .BLOCK_BYTES   (BLOCK_BYTES),
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .ctl       (ctl),
    .sts       (sts),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

/* rtl/bta_chk.sv */
// port-level checker for the block table allocator, bound to the top level
// depends on bta_pkg
module bta_chk (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input bta_pkg::bta_in_t  in_data,
  input logic              out_valid,
  input logic              out_stall,
  input bta_pkg::bta_out_t out_data
);
  import bta_pkg::*;

  // held result stays up
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("out_valid dropped under stall");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("out_data changed under stall");

  // one transaction in flight: input closes right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken twice in a row");

  a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.usage_percent <= 7'd100)
    else $error("usage above full");

  a_range_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == ST_RANGE || out_data.status == ST_FAIL)
      |-> out_data.granted_offset == '0 && out_data.allocated_bytes == '0)
    else $error("failed transaction carries offset or size");

endmodule

bind block_table_allocator_unit bta_chk u_bta_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

/* tb/bta_result_checker.sv */
`timescale 1ns / 1ps
// result checker for the block table allocator: keeps its own copy of the table,
// predicts one result per accepted request and compares every accepted result
// depends on bta_pkg
module bta_result_checker
  import bta_pkg::*;
#(
  parameter int BLOCK_BYTES   = 32,
  parameter int TABLE_ENTRIES = 256
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_stall,
  input  bta_in_t  in_data,
  input  logic     out_valid,
  input  logic     out_stall,
  input  bta_out_t out_data,
  output int       fail_count,
  output int       pending
);

  localparam int CNT_W      = $clog2(TABLE_ENTRIES + 1);
  localparam int POOL_BYTES = BLOCK_BYTES * TABLE_ENTRIES;

  logic [CNT_W-1:0] blk_count [TABLE_ENTRIES];
  logic [CNT_W-1:0] used_count;
  bta_out_t         predicted_replies [$];
  int               errors = 0;

  // applies one request to the table copy and returns the reply it should produce
  function automatic bta_out_t apply_to_table(bta_in_t req);
    bta_out_t    res;
    int unsigned need;
    int unsigned run;
    int unsigned idx;
    int unsigned cnt;
    bit          found;
    res        = '0;
    res.status = ST_OK;
    case (req.command)
      CMD_ALLOC: begin
        need  = (int'(req.request_bytes) + BLOCK_BYTES - 1) / BLOCK_BYTES;
        found = 1'b0;
        run   = 0;
        if (req.request_bytes != '0 && need <= TABLE_ENTRIES) begin
          // downward scan, the run grows toward lower entries
          for (int k = TABLE_ENTRIES - 1; k >= 0 && !found; k--) begin
            if (blk_count[k] == '0) run++;
            else run = 0;
            if (run == need) begin
              for (int i = 0; i < need; i++) blk_count[k + i] = CNT_W'(need);
              used_count         = used_count + CNT_W'(need);
              res.granted_offset = GRANT_W'(k * BLOCK_BYTES);
              found              = 1'b1;
            end
          end
        end
        if (!found) res.status = ST_FAIL;
      end
      CMD_FREE, CMD_QUERY: begin
        if (int'(req.byte_offset) >= POOL_BYTES) begin
          res.status = ST_RANGE;
        end else begin
          idx = int'(req.byte_offset) / BLOCK_BYTES;
          cnt = int'(blk_count[idx]);
          if (req.command == CMD_FREE) begin
            // may run into neighboring allocations, stops at the table end
            for (int i = 0; i < cnt && idx + i < TABLE_ENTRIES; i++) begin
              if (blk_count[idx + i] != '0) begin
                blk_count[idx + i] = '0;
                used_count         = used_count - 1'b1;
              end
            end
          end else begin
            res.allocated_bytes = BYTES_W'(cnt * BLOCK_BYTES);
          end
        end
      end
      default: ;
    endcase
    res.usage_percent = PCT_W'((int'(used_count) * PCT_SCALE) / TABLE_ENTRIES);
    return res;
  endfunction

  always @(posedge clk) begin
    bta_out_t want;
    if (!rst_n) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) blk_count[i] = '0;
      used_count = '0;
      predicted_replies.delete();
    end else begin
      // results first: a result never belongs to a request accepted on the same edge
      if (out_valid && !out_stall) begin
        if (predicted_replies.size() == 0) begin
          if (errors < 10)
            $display("[%0t] unexpected result: st=%0d off=%0d bytes=%0d pct=%0d", $realtime,
                     out_data.status, out_data.granted_offset, out_data.allocated_bytes,
                     out_data.usage_percent);
          errors++;
        end else begin
          want = predicted_replies.pop_front();
          if (want.status !== out_data.status ||
              want.granted_offset !== out_data.granted_offset ||
              want.allocated_bytes !== out_data.allocated_bytes ||
              want.usage_percent !== out_data.usage_percent) begin
            if (errors < 10)
              $display({"[%0t] mismatch: exp st=%0d off=%0d bytes=%0d pct=%0d,",
                        " got st=%0d off=%0d bytes=%0d pct=%0d"}, $realtime,
                       want.status, want.granted_offset, want.allocated_bytes,
                       want.usage_percent, out_data.status, out_data.granted_offset,
                       out_data.allocated_bytes, out_data.usage_percent);
            errors++;
          end
        end
      end
      if (in_valid && !in_stall) predicted_replies.push_back(apply_to_table(in_data));
    end
    pending    <= predicted_replies.size();
    fail_count <= errors;
  end

endmodule

/* tb/tb_block_table_allocator_unit.sv */
`timescale 1ns / 1ps
// testbench top for block_table_allocator_unit: clock, reset, request stimulus,
// result-side stalls and the verdict; checking lives in bta_result_checker
// depends on bta_pkg, bta_result_checker and the allocator rtl
module tb_block_table_allocator_unit;
  import bta_pkg::*;

  localparam int BLOCK_BYTES   = 32;
  localparam int TABLE_ENTRIES = 256;
  localparam int POOL_BYTES    = BLOCK_BYTES * TABLE_ENTRIES;
  localparam int RANDOM_ITEMS  = 730;
  localparam int PAUSE_AT      = 400;
  localparam int HOLD_CYCLES   = 1500;
  localparam int DRAIN_CYCLES  = 700;

  localparam logic [1:0] CMD_UNUSED = 2'd3;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  bta_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  bta_out_t out_data;

  int       fail_count;
  int       pending;
  int       results_seen = 0;
  int       live_offsets [$];

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  block_table_allocator_unit #(
    .BLOCK_BYTES  (BLOCK_BYTES),
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  bta_result_checker #(
    .BLOCK_BYTES  (BLOCK_BYTES),
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) checker_i (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .fail_count(fail_count),
    .pending   (pending)
  );

  // remember granted offsets so frees and queries mostly hit live allocations
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (out_data.status == ST_OK && out_data.granted_offset != '0)
        live_offsets.push_back(int'(out_data.granted_offset));
    end
  end

  task automatic offer(input logic [1:0] cmd, input int req, input int off);
    bta_in_t item;
    item.command       = cmd;
    item.request_bytes = REQ_W'(req);
    item.byte_offset   = OFF_W'(off);
    in_data  <= item;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic idle_gap();
    int r;
    int n;
    r = $urandom_range(99);
    if (r < 60) n = 0;
    else if (r < 90) n = $urandom_range(1, 3);
    else if (r < 97) n = $urandom_range(4, 10);
    else n = $urandom_range(20, 60);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  function automatic int pick_offset(bit take);
    int k;
    int o;
    if (live_offsets.size() > 0 && $urandom_range(3) != 0) begin
      k = $urandom_range(live_offsets.size() - 1);
      o = live_offsets[k];
      if (take) live_offsets.delete(k);
      // now and then land inside the run rather than at its start
      if ($urandom_range(9) == 0) o += BLOCK_BYTES * $urandom_range(1, 3);
      if ($urandom_range(1) == 1) o += $urandom_range(0, BLOCK_BYTES - 1);
    end else if ($urandom_range(4) != 0) begin
      o = $urandom_range(0, POOL_BYTES - 1);
    end else begin
      o = $urandom_range(0, 65535);
    end
    return o;
  endfunction

  function automatic int pick_size();
    int r;
    r = $urandom_range(99);
    if (r < 70) return $urandom_range(1, 256);
    if (r < 90) return $urandom_range(257, 2048);
    if (r < 97) return $urandom_range(0, 65535);
    return 0;
  endfunction

  task automatic offer_random();
    int r;
    r = $urandom_range(99);
    if (r < 40) offer(CMD_ALLOC, pick_size(), $urandom_range(0, 65535));
    else if (r < 75) offer(CMD_FREE, $urandom_range(0, 65535), pick_offset(1'b1));
    else if (r < 95) offer(CMD_QUERY, $urandom_range(0, 65535), pick_offset(1'b0));
    else offer(CMD_UNUSED, $urandom_range(0, 65535), $urandom_range(0, 65535));
  endtask

  // result side: random stalls, free-running stretches, one long hold-off
  initial begin
    bit held;
    int m;
    held = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      m = $urandom_range(9);
      if (!held && results_seen >= 150) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        @(posedge clk);
        held = 1'b1;
      end else if (m < 3) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(20, 120)) @(posedge clk);
      end else if (m < 8) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk);
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end else begin
        out_stall <= 1'b1;
        repeat ($urandom_range(20, 60)) @(posedge clk);
        out_stall <= 1'b0;
        @(posedge clk);
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // whole pool in one run, then clipped and overlapping frees
    offer(CMD_ALLOC, POOL_BYTES, 0);                idle_gap();
    offer(CMD_QUERY, 0, 0);                         idle_gap();
    offer(CMD_QUERY, 16'hFFFF, POOL_BYTES - 1);     idle_gap();
    offer(CMD_FREE, 0, 100);                        idle_gap();
    offer(CMD_QUERY, 0, 0);                         idle_gap();
    offer(CMD_FREE, 0, 0);                          idle_gap();
    offer(CMD_FREE, 0, 0);                          idle_gap();
    // zero size and no fit
    offer(CMD_ALLOC, 0, 0);                         idle_gap();
    offer(CMD_ALLOC, 65535, 16'hFFFF);              idle_gap();
    offer(CMD_ALLOC, POOL_BYTES + 1, 0);            idle_gap();
    // small runs packed from the top down
    offer(CMD_ALLOC, 1, 0);                         idle_gap();
    offer(CMD_ALLOC, BLOCK_BYTES, 0);               idle_gap();
    offer(CMD_ALLOC, BLOCK_BYTES + 1, 0);           idle_gap();
    offer(CMD_QUERY, 0, POOL_BYTES - 4 * BLOCK_BYTES - 1);
    idle_gap();
    offer(CMD_FREE, 0, POOL_BYTES - 3 * BLOCK_BYTES);
    idle_gap();
    // offsets outside the pool, then the last byte inside it
    offer(CMD_FREE, 0, POOL_BYTES);                 idle_gap();
    offer(CMD_QUERY, 0, 65535);                     idle_gap();
    offer(CMD_FREE, 65535, 65535);                  idle_gap();
    offer(CMD_QUERY, 0, POOL_BYTES - 1);            idle_gap();
    // unused command
    offer(CMD_UNUSED, 65535, 65535);                idle_gap();
    offer(CMD_UNUSED, 0, 0);                        idle_gap();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      offer_random();
      if (n == RANDOM_ITEMS - 1) begin
        in_valid <= 1'b0;
      end else if (n == PAUSE_AT) begin
        // sender waits for every outstanding result
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end else begin
        idle_gap();
      end
    end

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #6000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
